FILE: rtl/qtp_pkg.sv
// Package for the quintic takeoff profile unit: field widths, register
// indexes, reset values, blend coefficients, datapath operations and the microcode table.
// Depends on nothing.
`default_nettype none

package qtp_pkg;

   localparam int DUR_W       = 16;
   localparam int TICK_W      = 10;
   localparam int POS_W       = 24;
   localparam int RATE_W      = 32;
   localparam int DZ_MAG_W    = POS_W + 1;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   // Divider numerator widths, from the value bounds of each division:
   // acceleration first pass (FRAC_BITS + 37), its quotient (FRAC_BITS + 31),
   // velocity (35) and acceleration second pass (41).
   localparam int ACC1_NUM_EXTRA = 37;
   localparam int A1_EXTRA       = 31;
   localparam int VEL_NUM_W      = 35;
   localparam int ACC2_NUM_W     = 41;

   localparam logic [DUR_W-1:0]  MIN_DURATION_MS = 16'd100;
   localparam int                MS_PER_S        = 1000;
   localparam logic [DUR_W-1:0]  DURATION_RESET  = 16'd3000;
   localparam logic [TICK_W-1:0] TICK_RESET      = 10'd20;
   localparam logic [POS_W-1:0]  TARGET_Z_RESET  = 24'hFFF830;

   localparam int K_POS_3 = 10;
   localparam int K_POS_4 = 15;
   localparam int K_POS_5 = 6;
   localparam int K_VEL_2 = 30;
   localparam int K_VEL_3 = 60;
   localparam int K_VEL_4 = 30;
   localparam int K_ACC_1 = 60;
   localparam int K_ACC_2 = 180;
   localparam int K_ACC_3 = 120;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DURATION = 3'd0,
      CSR_TICK     = 3'd1,
      CSR_START_X  = 3'd2,
      CSR_START_Y  = 3'd3,
      CSR_START_Z  = 3'd4,
      CSR_TARGET_Z = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [DUR_W-1:0]  duration_ms;
      logic [TICK_W-1:0] tick_ms;
      logic [POS_W-1:0]  start_x_mm;
      logic [POS_W-1:0]  start_y_mm;
      logic [POS_W-1:0]  start_z_mm;
      logic [POS_W-1:0]  target_z_mm;
   } cfg_type;

   typedef enum logic [4:0] {
      OP_NOP,
      OP_ACCEPT,
      OP_DIV_S,
      OP_S,
      OP_S2,
      OP_S3,
      OP_S4,
      OP_S5,
      OP_BLEND_POS,
      OP_BLEND_VEL,
      OP_BLEND_ACC,
      OP_MUL_POS,
      OP_POS,
      OP_MUL_VEL,
      OP_DIV_VEL,
      OP_VEL,
      OP_MUL_ACC,
      OP_DIV_ACC1,
      OP_DIV_ACC2,
      OP_ACC,
      OP_OUT
   } op_type;

   typedef enum logic [1:0] {
      C_NONE,
      C_NO_REQ,
      C_DIV_BUSY,
      C_OUT_FULL
   } cond_type;

   localparam int STEP_W      = 5;
   localparam int UCODE_DEPTH = 24;

   localparam logic [STEP_W-1:0] STEP_IDLE      = 5'd0;
   localparam logic [STEP_W-1:0] STEP_WAIT_S    = 5'd2;
   localparam logic [STEP_W-1:0] STEP_WAIT_VEL  = 5'd15;
   localparam logic [STEP_W-1:0] STEP_WAIT_ACC1 = 5'd19;
   localparam logic [STEP_W-1:0] STEP_WAIT_ACC2 = 5'd21;
   localparam logic [STEP_W-1:0] STEP_OUT       = 5'd23;

   // When cond holds, the step jumps to target and its operation is held off.
   typedef struct packed {
      op_type            op;
      cond_type          cond;
      logic [STEP_W-1:0] target;
      logic              last;
   } ucode_type;

   localparam ucode_type UCODE [UCODE_DEPTH] = '{
      '{OP_ACCEPT,    C_NO_REQ,   STEP_IDLE,      1'b0},
      '{OP_DIV_S,     C_NONE,     STEP_IDLE,      1'b0},
      '{OP_NOP,       C_DIV_BUSY, STEP_WAIT_S,    1'b0},
      '{OP_S,         C_NONE,     STEP_IDLE,      1'b0},
      '{OP_S2,        C_NONE,     STEP_IDLE,      1'b0},
      '{OP_S3,        C_NONE,     STEP_IDLE,      1'b0},
      '{OP_S4,        C_NONE,     STEP_IDLE,      1'b0},
      '{OP_S5,        C_NONE,     STEP_IDLE,      1'b0},
      '{OP_BLEND_POS, C_NONE,     STEP_IDLE,      1'b0},
      '{OP_BLEND_VEL, C_NONE,     STEP_IDLE,      1'b0},
      '{OP_BLEND_ACC, C_NONE,     STEP_IDLE,      1'b0},
      '{OP_MUL_POS,   C_NONE,     STEP_IDLE,      1'b0},
      '{OP_POS,       C_NONE,     STEP_IDLE,      1'b0},
      '{OP_MUL_VEL,   C_NONE,     STEP_IDLE,      1'b0},
      '{OP_DIV_VEL,   C_NONE,     STEP_IDLE,      1'b0},
      '{OP_NOP,       C_DIV_BUSY, STEP_WAIT_VEL,  1'b0},
      '{OP_VEL,       C_NONE,     STEP_IDLE,      1'b0},
      '{OP_MUL_ACC,   C_NONE,     STEP_IDLE,      1'b0},
      '{OP_DIV_ACC1,  C_NONE,     STEP_IDLE,      1'b0},
      '{OP_NOP,       C_DIV_BUSY, STEP_WAIT_ACC1, 1'b0},
      '{OP_DIV_ACC2,  C_NONE,     STEP_IDLE,      1'b0},
      '{OP_NOP,       C_DIV_BUSY, STEP_WAIT_ACC2, 1'b0},
      '{OP_ACC,       C_NONE,     STEP_IDLE,      1'b0},
      '{OP_OUT,       C_OUT_FULL, STEP_OUT,       1'b1}
   };

endpackage

`default_nettype wire

FILE: rtl/quintic_takeoff_profile_unit.sv
// Quintic minimum-jerk takeoff setpoint generator. Each request word is one
// control tick: the elapsed time restarts or advances by the tick period,
// saturating at the takeoff duration (at least 100 ms), and the response word
// carries the x/y start position, the blended height, the vertical velocity
// and acceleration (saturated to 32 bits) and a done flag once normalized
// time reaches one. Each word runs four divisions through the serial
// divider, which produces one quotient bit per cycle; the next request is
// taken as soon as the previous response is loaded into the output register.
// Configuration writes are taken every cycle and must only be issued while
// no word is in flight.
// Depends on qtp_pkg, qtp_sequencer, qtp_datapath and qtp_divider.
`default_nettype none

module quintic_takeoff_profile_unit import qtp_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_restart,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic signed [POS_W-1:0]     rsp_pos_x_mm,
   output logic signed [POS_W-1:0]     rsp_pos_y_mm,
   output logic signed [POS_W-1:0]     rsp_pos_z_mm,
   output logic signed [RATE_W-1:0]    rsp_vel_z_mm_s,
   output logic signed [RATE_W-1:0]    rsp_acc_z_mm_s2,
   output logic                        rsp_done_res,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   op_type  op;
   logic    div_busy;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DURATION: cfg_in.duration_ms = csr_wdata[DUR_W-1:0];
            CSR_TICK:     cfg_in.tick_ms     = csr_wdata[TICK_W-1:0];
            CSR_START_X:  cfg_in.start_x_mm  = csr_wdata[POS_W-1:0];
            CSR_START_Y:  cfg_in.start_y_mm  = csr_wdata[POS_W-1:0];
            CSR_START_Z:  cfg_in.start_z_mm  = csr_wdata[POS_W-1:0];
            CSR_TARGET_Z: cfg_in.target_z_mm = csr_wdata[POS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.duration_ms <= DURATION_RESET;
         cfg_ff.tick_ms     <= TICK_RESET;
         cfg_ff.start_x_mm  <= '0;
         cfg_ff.start_y_mm  <= '0;
         cfg_ff.start_z_mm  <= '0;
         cfg_ff.target_z_mm <= TARGET_Z_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   qtp_sequencer u_sequencer (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .div_busy(div_busy),
      .op(op)
   );

   qtp_datapath #(
      .FRAC_BITS(FRAC_BITS)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .op(op),
      .cfg(cfg_ff),
      .restart(req_restart),
      .div_busy(div_busy),
      .pos_x_mm(rsp_pos_x_mm),
      .pos_y_mm(rsp_pos_y_mm),
      .pos_z_mm(rsp_pos_z_mm),
      .vel_z_mm_s(rsp_vel_z_mm_s),
      .acc_z_mm_s2(rsp_acc_z_mm_s2),
      .done_res(rsp_done_res)
   );

endmodule

`default_nettype wire

FILE: rtl/qtp_divider.sv
// Restoring serial divider for the quintic takeoff profile unit, one
// quotient bit per cycle with a 16-bit divisor. Depends on qtp_pkg.
`default_nettype none

module qtp_divider import qtp_pkg::*; #(
   parameter int NUM_W = 53,
   localparam int LEN_W = $clog2(NUM_W + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [LEN_W-1:0] len,
   input  wire logic [DUR_W-1:0] den,
   output logic                  busy,
   output logic [NUM_W-1:0]      quo
);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DUR_W-1:0] rem_ff, rem_in;
   logic [DUR_W-1:0] den_ff, den_in;
   logic [LEN_W-1:0] cnt_ff, cnt_in;
   logic [DUR_W:0]   trial;
   logic [DUR_W:0]   diff;
   logic             ge;

   assign busy = (cnt_ff != '0);
   assign quo  = quo_ff;

   // The numerator arrives left aligned, so len steps leave the quotient
   // in the low bits of quo_ff.
   always_comb begin
      trial  = {rem_ff, num_ff[NUM_W-1]};
      diff   = trial - {1'b0, den_ff};
      ge     = (trial >= {1'b0, den_ff});
      num_in = num_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      if (start) begin
         num_in = num;
         quo_in = '0;
         rem_in = '0;
         den_in = den;
         cnt_in = len;
      end else if (busy) begin
         num_in = {num_ff[NUM_W-2:0], 1'b0};
         quo_in = {quo_ff[NUM_W-2:0], ge};
         rem_in = ge ? diff[DUR_W-1:0] : trial[DUR_W-1:0];
         cnt_in = cnt_ff - LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

endmodule

`default_nettype wire

FILE: rtl/qtp_datapath.sv
// Datapath of the quintic takeoff profile unit: elapsed-time counter, power
// and blend registers, one shared multiplier, the serial divider and the
// result word registers. Depends on qtp_pkg and qtp_divider.
`default_nettype none

module qtp_datapath import qtp_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire op_type                   op,
   input  wire cfg_type                  cfg,
   input  wire logic                     restart,
   output logic                          div_busy,
   output logic signed [POS_W-1:0]       pos_x_mm,
   output logic signed [POS_W-1:0]       pos_y_mm,
   output logic signed [POS_W-1:0]       pos_z_mm,
   output logic signed [RATE_W-1:0]      vel_z_mm_s,
   output logic signed [RATE_W-1:0]      acc_z_mm_s2,
   output logic                          done_res
);

   localparam int S_W    = FRAC_BITS + 1;
   localparam int BL_W   = FRAC_BITS + 4;
   localparam int BX_W   = FRAC_BITS + 10;
   localparam int MA_W   = DZ_MAG_W;
   localparam int P_W    = MA_W + BL_W;
   localparam int PK_W   = P_W + 10;
   localparam int ZS_W   = P_W - FRAC_BITS + 2;
   localparam int NUM_W  = FRAC_BITS + ACC1_NUM_EXTRA;
   localparam int A1_W   = FRAC_BITS + A1_EXTRA;
   localparam int A1K_W  = A1_W + 10;
   localparam int LEN_W  = $clog2(NUM_W + 1);
   localparam int LEN_S  = FRAC_BITS + DUR_W;

   localparam logic [S_W-1:0]   S_ONE   = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [NUM_W-1:0] S_ONE_N = NUM_W'(S_ONE);

   localparam logic signed [BX_W-1:0] C_P3 = BX_W'(K_POS_3);
   localparam logic signed [BX_W-1:0] C_P4 = BX_W'(K_POS_4);
   localparam logic signed [BX_W-1:0] C_P5 = BX_W'(K_POS_5);
   localparam logic signed [BX_W-1:0] C_V2 = BX_W'(K_VEL_2);
   localparam logic signed [BX_W-1:0] C_V3 = BX_W'(K_VEL_3);
   localparam logic signed [BX_W-1:0] C_V4 = BX_W'(K_VEL_4);
   localparam logic signed [BX_W-1:0] C_A1 = BX_W'(K_ACC_1);
   localparam logic signed [BX_W-1:0] C_A2 = BX_W'(K_ACC_2);
   localparam logic signed [BX_W-1:0] C_A3 = BX_W'(K_ACC_3);

   logic [DUR_W-1:0]        elapsed_ff, elapsed_in;
   logic [S_W-1:0]          s_ff, s_in, s2_ff, s2_in, s3_ff, s3_in;
   logic [S_W-1:0]          s4_ff, s4_in, s5_ff, s5_in;
   logic signed [BL_W-1:0]  b_ff, b_in, bv_ff, bv_in, ba_ff, ba_in;
   logic [P_W-1:0]          prod_ff, prod_in;
   logic                    neg_ff, neg_in;
   logic [POS_W-1:0]        posz_ff, posz_in;
   logic [RATE_W-1:0]       vel_ff, vel_in, acc_ff, acc_in;
   logic [POS_W-1:0]        rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in, rsp_z_ff, rsp_z_in;
   logic [RATE_W-1:0]       rsp_vel_ff, rsp_vel_in, rsp_acc_ff, rsp_acc_in;
   logic                    rsp_done_ff, rsp_done_in;

   logic [DUR_W-1:0]        d_eff;
   logic [DUR_W:0]          tick_sum;
   logic signed [BX_W-1:0]  s1x, s2x, s3x, s4x, s5x;
   logic signed [BX_W-1:0]  b_x, bv_x, ba_x;
   logic signed [DZ_MAG_W-1:0] dz;
   logic                    dz_neg;
   logic [MA_W-1:0]         dz_mag;
   logic signed [BL_W-1:0]  blend_sel;
   logic                    blend_neg;
   logic [BL_W-1:0]         blend_mag;
   logic [MA_W-1:0]         mul_a;
   logic [BL_W-1:0]         mul_b;
   logic [P_W-1:0]          mul_p;
   logic [PK_W-1:0]         prod_k;
   logic [A1K_W-1:0]        a1k;
   logic signed [ZS_W-1:0]  sz_x, sh_x, z_x;
   logic [POS_W-1:0]        z_sat;
   logic [S_W-1:0]          s_clamp;
   logic                    div_start;
   logic [NUM_W-1:0]        div_num;
   logic [LEN_W-1:0]        div_len;
   logic [NUM_W-1:0]        quo;

   // Saturate a magnitude with a sign to a 32-bit two's complement value.
   function automatic logic [RATE_W-1:0] sat_rate(input logic [NUM_W-1:0] mag,
                                                   input logic neg);
      logic [NUM_W-1:0] lim;
      lim = NUM_W'(1) << (RATE_W - 1);
      if (neg) begin
         sat_rate = (mag > lim) ? lim[RATE_W-1:0] : RATE_W'(0) - mag[RATE_W-1:0];
      end else begin
         sat_rate = (mag > lim - NUM_W'(1)) ? lim[RATE_W-1:0] - RATE_W'(1)
                                           : mag[RATE_W-1:0];
      end
   endfunction

   assign d_eff    = (cfg.duration_ms < MIN_DURATION_MS) ? MIN_DURATION_MS : cfg.duration_ms;
   assign tick_sum = {1'b0, elapsed_ff} + (DUR_W + 1)'(cfg.tick_ms);

   assign s1x = signed'(BX_W'(s_ff));
   assign s2x = signed'(BX_W'(s2_ff));
   assign s3x = signed'(BX_W'(s3_ff));
   assign s4x = signed'(BX_W'(s4_ff));
   assign s5x = signed'(BX_W'(s5_ff));
   assign b_x  = C_P3 * s3x - C_P4 * s4x + C_P5 * s5x;
   assign bv_x = C_V2 * s2x - C_V3 * s3x + C_V4 * s4x;
   assign ba_x = C_A1 * s1x - C_A2 * s2x + C_A3 * s3x;

   assign dz     = signed'({cfg.target_z_mm[POS_W-1], cfg.target_z_mm})
                 - signed'({cfg.start_z_mm[POS_W-1], cfg.start_z_mm});
   assign dz_neg = dz[DZ_MAG_W-1];
   assign dz_mag = dz_neg ? MA_W'(0) - MA_W'(dz) : MA_W'(dz);

   always_comb begin
      case (op)
         OP_MUL_POS: blend_sel = b_ff;
         OP_MUL_VEL: blend_sel = bv_ff;
         default:    blend_sel = ba_ff;
      endcase
      blend_neg = blend_sel[BL_W-1];
      blend_mag = blend_neg ? BL_W'(0) - BL_W'(blend_sel) : BL_W'(blend_sel);
   end

   // One shared multiplier: powers of s, then |dz| times a blend magnitude.
   always_comb begin
      case (op)
         OP_S2: begin
            mul_a = MA_W'(s_ff);
            mul_b = BL_W'(s_ff);
         end
         OP_S3: begin
            mul_a = MA_W'(s2_ff);
            mul_b = BL_W'(s_ff);
         end
         OP_S4: begin
            mul_a = MA_W'(s3_ff);
            mul_b = BL_W'(s_ff);
         end
         OP_S5: begin
            mul_a = MA_W'(s4_ff);
            mul_b = BL_W'(s_ff);
         end
         default: begin
            mul_a = dz_mag;
            mul_b = blend_mag;
         end
      endcase
      mul_p = P_W'(mul_a) * P_W'(mul_b);
   end

   assign prod_k = PK_W'(prod_ff) * PK_W'(MS_PER_S);
   assign a1k    = A1K_W'(quo[A1_W-1:0]) * A1K_W'(MS_PER_S);

   assign sz_x  = signed'({{(ZS_W - POS_W){cfg.start_z_mm[POS_W-1]}}, cfg.start_z_mm});
   assign sh_x  = signed'(ZS_W'(prod_ff[P_W-1:FRAC_BITS]));
   assign z_x   = neg_ff ? sz_x - sh_x : sz_x + sh_x;
   // The sum fits in 24 bits when all bits above bit 22 agree.
   assign z_sat = ((&z_x[ZS_W-1:POS_W-1]) || !(|z_x[ZS_W-1:POS_W-1]))
                ? z_x[POS_W-1:0]
                : (z_x[ZS_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}});

   assign s_clamp = (quo > S_ONE_N) ? S_ONE : quo[S_W-1:0];

   always_comb begin
      div_start = 1'b0;
      div_num   = '0;
      div_len   = '0;
      case (op)
         OP_DIV_S: begin
            div_start = 1'b1;
            div_num   = {elapsed_ff, {(NUM_W - DUR_W){1'b0}}};
            div_len   = LEN_W'(LEN_S);
         end
         OP_DIV_VEL: begin
            div_start = 1'b1;
            div_num   = {prod_k[FRAC_BITS +: VEL_NUM_W], {(NUM_W - VEL_NUM_W){1'b0}}};
            div_len   = LEN_W'(VEL_NUM_W);
         end
         OP_DIV_ACC1: begin
            div_start = 1'b1;
            div_num   = prod_k[NUM_W-1:0];
            div_len   = LEN_W'(NUM_W);
         end
         OP_DIV_ACC2: begin
            div_start = 1'b1;
            div_num   = {a1k[FRAC_BITS +: ACC2_NUM_W], {(NUM_W - ACC2_NUM_W){1'b0}}};
            div_len   = LEN_W'(ACC2_NUM_W);
         end
         default: ;
      endcase
   end

   qtp_divider #(
      .NUM_W(NUM_W)
   ) u_divider (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num(div_num),
      .len(div_len),
      .den(d_eff),
      .busy(div_busy),
      .quo(quo)
   );

   always_comb begin
      elapsed_in  = elapsed_ff;
      s_in        = s_ff;
      s2_in       = s2_ff;
      s3_in       = s3_ff;
      s4_in       = s4_ff;
      s5_in       = s5_ff;
      b_in        = b_ff;
      bv_in       = bv_ff;
      ba_in       = ba_ff;
      prod_in     = prod_ff;
      neg_in      = neg_ff;
      posz_in     = posz_ff;
      vel_in      = vel_ff;
      acc_in      = acc_ff;
      rsp_x_in    = rsp_x_ff;
      rsp_y_in    = rsp_y_ff;
      rsp_z_in    = rsp_z_ff;
      rsp_vel_in  = rsp_vel_ff;
      rsp_acc_in  = rsp_acc_ff;
      rsp_done_in = rsp_done_ff;
      case (op)
         OP_ACCEPT: begin
            if (restart) begin
               elapsed_in = '0;
            end else if (tick_sum > {1'b0, d_eff}) begin
               elapsed_in = d_eff;
            end else begin
               elapsed_in = tick_sum[DUR_W-1:0];
            end
         end
         OP_S:         s_in  = s_clamp;
         OP_S2:        s2_in = mul_p[FRAC_BITS +: S_W];
         OP_S3:        s3_in = mul_p[FRAC_BITS +: S_W];
         OP_S4:        s4_in = mul_p[FRAC_BITS +: S_W];
         OP_S5:        s5_in = mul_p[FRAC_BITS +: S_W];
         OP_BLEND_POS: b_in  = b_x[BL_W-1:0];
         OP_BLEND_VEL: bv_in = bv_x[BL_W-1:0];
         OP_BLEND_ACC: ba_in = ba_x[BL_W-1:0];
         OP_MUL_POS, OP_MUL_VEL, OP_MUL_ACC: begin
            prod_in = mul_p;
            neg_in  = dz_neg ^ blend_neg;
         end
         OP_POS:       posz_in = z_sat;
         OP_VEL:       vel_in  = sat_rate(quo, neg_ff);
         OP_ACC:       acc_in  = sat_rate(quo, neg_ff);
         OP_OUT: begin
            rsp_x_in    = cfg.start_x_mm;
            rsp_y_in    = cfg.start_y_mm;
            rsp_z_in    = posz_ff;
            rsp_vel_in  = vel_ff;
            rsp_acc_in  = acc_ff;
            rsp_done_in = (s_ff == S_ONE);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
      end else begin
         elapsed_ff <= elapsed_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff        <= s_in;
      s2_ff       <= s2_in;
      s3_ff       <= s3_in;
      s4_ff       <= s4_in;
      s5_ff       <= s5_in;
      b_ff        <= b_in;
      bv_ff       <= bv_in;
      ba_ff       <= ba_in;
      prod_ff     <= prod_in;
      neg_ff      <= neg_in;
      posz_ff     <= posz_in;
      vel_ff      <= vel_in;
      acc_ff      <= acc_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_z_ff    <= rsp_z_in;
      rsp_vel_ff  <= rsp_vel_in;
      rsp_acc_ff  <= rsp_acc_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign pos_x_mm    = signed'(rsp_x_ff);
   assign pos_y_mm    = signed'(rsp_y_ff);
   assign pos_z_mm    = signed'(rsp_z_ff);
   assign vel_z_mm_s  = signed'(rsp_vel_ff);
   assign acc_z_mm_s2 = signed'(rsp_acc_ff);
   assign done_res    = rsp_done_ff;

endmodule

`default_nettype wire

FILE: rtl/qtp_sequencer.sv
// Microcode sequencer of the quintic takeoff profile unit: step counter,
// control word fetch, conditional jumps and the result valid flag.
// Depends on qtp_pkg.
`default_nettype none

module qtp_sequencer import qtp_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   input  wire logic div_busy,
   output op_type    op
);

   logic [STEP_W-1:0] pc_ff, pc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   ucode_type         word;
   logic              hold;

   assign word = UCODE[pc_ff];

   always_comb begin
      case (word.cond)
         C_NONE:     hold = 1'b0;
         C_NO_REQ:   hold = !req_valid;
         C_DIV_BUSY: hold = div_busy;
         C_OUT_FULL: hold = rsp_valid_ff && !rsp_ready;
         default:    hold = 1'b0;
      endcase

      if (hold) begin
         pc_in = word.target;
      end else if (word.last) begin
         pc_in = STEP_IDLE;
      end else begin
         pc_in = pc_ff + STEP_W'(1);
      end

      op = hold ? OP_NOP : word.op;

      // A new word loads the output register in the same cycle the old one leaves.
      if (op == OP_OUT) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign req_ready = (word.cond == C_NO_REQ);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= STEP_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire
